// ===== hdl/instruction_decode_control_unit_defines.svh =====
// Assertion macros shared by the files of the instruction decode control unit.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef INSTRUCTION_DECODE_CONTROL_UNIT_DEFINES_SVH
`define INSTRUCTION_DECODE_CONTROL_UNIT_DEFINES_SVH

// The consequent is checked in the same cycle as the antecedent, outside reset.
`define IDCU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("decode unit check failed");

// The consequent is checked in the cycle after the antecedent, outside reset.
`define IDCU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("decode unit check failed");

// The consequent is checked in the cycle after the antecedent, during reset too.
`define IDCU_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("decode unit reset check failed");

`endif

// ===== hdl/idcu_pkg.sv =====
`default_nettype none

package idcu_pkg;

    // Field widths of the instruction word and the flags.
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned FLAGS_W = 4;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned SUB_W   = 4;
    localparam int unsigned REG_W   = 3;
    localparam int unsigned ALU_W   = 5;
    localparam int unsigned PORT_W  = 2;

    // Stream widths: both rounded up to whole bytes.
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 32;

    // Major opcodes.
    localparam logic [OP_W-1:0] OP_ALU      = 3'd0;
    localparam logic [OP_W-1:0] OP_ALU_EXT  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_IMM = 3'd2;
    localparam logic [OP_W-1:0] OP_MEM      = 3'd3;
    localparam logic [OP_W-1:0] OP_JUMP     = 3'd4;
    localparam logic [OP_W-1:0] OP_STACK    = 3'd5;
    localparam logic [OP_W-1:0] OP_IO       = 3'd7;

    // Sub-opcodes.
    localparam logic [SUB_W-1:0] SUB_ALU_LAST   = 4'd9;
    localparam logic [SUB_W-1:0] SUB_FLAG_OP    = 4'd10;
    localparam logic [SUB_W-1:0] SUB_WRITE_OP   = 4'd11;
    localparam logic [SUB_W-1:0] SUB_LOAD_DIR   = 4'd0;
    localparam logic [SUB_W-1:0] SUB_STORE_DIR  = 4'd1;
    localparam logic [SUB_W-1:0] SUB_STORE_IND  = 4'd2;
    localparam logic [SUB_W-1:0] SUB_LOAD_IND   = 4'd3;
    localparam logic [SUB_W-1:0] SUB_JSR        = 4'd11;
    localparam logic [SUB_W-1:0] SUB_RTS        = 4'd12;
    localparam logic [SUB_W-1:0] SUB_POP        = 4'd1;
    localparam logic [SUB_W-1:0] SUB_HALT       = 4'd0;
    localparam logic [SUB_W-1:0] SUB_IN_FIRST   = 4'd1;
    localparam logic [SUB_W-1:0] SUB_IN_LAST    = 4'd3;
    localparam logic [SUB_W-1:0] SUB_OUT_FIRST  = 4'd4;
    localparam logic [SUB_W-1:0] SUB_OUT_LAST   = 4'd6;

    // Branch condition selectors (sub-opcode of a jump).
    localparam logic [SUB_W-1:0] BR_ALWAYS      = 4'd0;
    localparam logic [SUB_W-1:0] BR_F0          = 4'd1;
    localparam logic [SUB_W-1:0] BR_NOT_F0      = 4'd2;
    localparam logic [SUB_W-1:0] BR_F2          = 4'd3;
    localparam logic [SUB_W-1:0] BR_F0_OR_F2    = 4'd4;
    localparam logic [SUB_W-1:0] BR_NOR_F0_F2   = 4'd5;
    localparam logic [SUB_W-1:0] BR_NOT_F2      = 4'd6;
    localparam logic [SUB_W-1:0] BR_X13         = 4'd7;
    localparam logic [SUB_W-1:0] BR_F0_OR_X13   = 4'd8;
    localparam logic [SUB_W-1:0] BR_NOR_F0_X13  = 4'd9;
    localparam logic [SUB_W-1:0] BR_X13_ALT     = 4'd10;
    localparam logic [SUB_W-1:0] BR_ALWAYS_CALL = 4'd11;

    // ALU operation codes.
    localparam logic [ALU_W-1:0] ALU_NONE    = 5'd0;
    localparam logic [ALU_W-1:0] ALU_BASE    = 5'd16;
    localparam logic [ALU_W-1:0] ALU_FLAG_OP = 5'd26;
    localparam logic [ALU_W-1:0] ALU_EXT_OP  = 5'd27;

    // Control groups; the last member of each sits in bit 0.
    typedef struct packed {
        logic mem_wr;
        logic flg_wr;
        logic reg_wr;
    } t_write_en;

    typedef struct packed {
        logic reg_is_addr;
        logic mem_to_reg;
        logic has_addr;
        logic next_word;
    } t_operand;

    typedef struct packed {
        logic ret;
        logic jsr;
        logic stack_change;
        logic stack_pop;
        logic load_pc;
    } t_flow;

    typedef struct packed {
        logic use_out;
        logic use_in;
        logic halt;
    } t_io;

    // One decoded result.
    typedef struct packed {
        logic [ALU_W-1:0]  alu_operation;
        logic [REG_W-1:0]  dest_register;
        logic [REG_W-1:0]  source_a_register;
        logic [REG_W-1:0]  source_b_register;
        logic [PORT_W-1:0] io_port_number;
        t_write_en         write_enables;
        t_operand          operand_controls;
        t_flow             flow_controls;
        t_io               io_halt_controls;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/idcu_branch_cond.sv =====
`default_nettype none

module idcu_branch_cond (
    input  wire logic [idcu_pkg::SUB_W-1:0]   i_sub,
    input  wire logic [idcu_pkg::FLAGS_W-1:0] i_flags,
    output logic                              o_taken
);

    logic w_x13;

    // The overflow-style test used by several conditions.
    assign w_x13 = i_flags[1] ^ i_flags[3];

    // Select one test of the flags by sub-opcode; unused codes never branch.
    always_comb begin
        unique case (i_sub)
            idcu_pkg::BR_ALWAYS:      o_taken = 1'b1;
            idcu_pkg::BR_F0:          o_taken = i_flags[0];
            idcu_pkg::BR_NOT_F0:      o_taken = ~i_flags[0];
            idcu_pkg::BR_F2:          o_taken = i_flags[2];
            idcu_pkg::BR_F0_OR_F2:    o_taken = i_flags[0] | i_flags[2];
            idcu_pkg::BR_NOR_F0_F2:   o_taken = ~(i_flags[0] | i_flags[2]);
            idcu_pkg::BR_NOT_F2:      o_taken = ~i_flags[2];
            idcu_pkg::BR_X13:         o_taken = w_x13;
            idcu_pkg::BR_F0_OR_X13:   o_taken = i_flags[0] | w_x13;
            idcu_pkg::BR_NOR_F0_X13:  o_taken = ~w_x13 & ~i_flags[0];
            idcu_pkg::BR_X13_ALT:     o_taken = w_x13;
            idcu_pkg::BR_ALWAYS_CALL: o_taken = 1'b1;
            default:                  o_taken = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/idcu_decode.sv =====
`default_nettype none

module idcu_decode (
    input  wire logic [idcu_pkg::WORD_W-1:0]  i_word,
    input  wire logic [idcu_pkg::FLAGS_W-1:0] i_flags,
    output idcu_pkg::t_result                 o_result
);

    logic [idcu_pkg::OP_W-1:0]  w_op;
    logic [idcu_pkg::SUB_W-1:0] w_sub;
    logic                       w_taken;
    logic                       w_in_range;
    logic                       w_out_range;
    logic                       w_out_any;

    // Split the instruction word into its fields.
    assign w_op  = i_word[15:13];
    assign w_sub = i_word[12:9];

    idcu_branch_cond u_branch (
        .i_sub   (w_sub),
        .i_flags (i_flags),
        .o_taken (w_taken)
    );

    // Sub-opcode ranges of the I/O group.
    assign w_in_range  = (w_sub >= idcu_pkg::SUB_IN_FIRST) && (w_sub <= idcu_pkg::SUB_IN_LAST);
    assign w_out_range = (w_sub >= idcu_pkg::SUB_OUT_FIRST) && (w_sub <= idcu_pkg::SUB_OUT_LAST);
    assign w_out_any   = (w_sub >= idcu_pkg::SUB_OUT_FIRST);

    // Build every control from the opcode, the sub-opcode and, for jumps, the flags.
    always_comb begin
        o_result = '0;

        o_result.dest_register     = i_word[8:6];
        o_result.source_a_register = i_word[5:3];
        o_result.source_b_register = i_word[2:0];

        // ALU operation.
        if (w_op == idcu_pkg::OP_ALU && w_sub <= idcu_pkg::SUB_ALU_LAST) begin
            o_result.alu_operation = idcu_pkg::ALU_BASE + idcu_pkg::ALU_W'(w_sub);
        end else if (w_op == idcu_pkg::OP_ALU_EXT && w_sub == idcu_pkg::SUB_FLAG_OP) begin
            o_result.alu_operation = idcu_pkg::ALU_FLAG_OP;
        end else if (w_op == idcu_pkg::OP_ALU_EXT && w_sub == idcu_pkg::SUB_WRITE_OP) begin
            o_result.alu_operation = idcu_pkg::ALU_EXT_OP;
        end else begin
            o_result.alu_operation = idcu_pkg::ALU_NONE;
        end

        // Write enables.
        o_result.write_enables.reg_wr =
              (w_op == idcu_pkg::OP_ALU) || (w_op == idcu_pkg::OP_LOAD_IMM)
           || (w_op == idcu_pkg::OP_ALU_EXT && w_sub == idcu_pkg::SUB_WRITE_OP)
           || (w_op == idcu_pkg::OP_MEM && (w_sub == idcu_pkg::SUB_LOAD_DIR
                                          || w_sub == idcu_pkg::SUB_LOAD_IND))
           || (w_op == idcu_pkg::OP_STACK && w_sub == idcu_pkg::SUB_POP)
           || (w_op == idcu_pkg::OP_IO && w_in_range);
        o_result.write_enables.flg_wr =
            (w_op == idcu_pkg::OP_ALU_EXT && w_sub == idcu_pkg::SUB_FLAG_OP);
        o_result.write_enables.mem_wr =
            (w_op == idcu_pkg::OP_MEM && (w_sub == idcu_pkg::SUB_STORE_DIR
                                        || w_sub == idcu_pkg::SUB_STORE_IND));

        // Operand and addressing controls; jumps take their address only when taken.
        o_result.operand_controls.next_word =
              (w_op == idcu_pkg::OP_LOAD_IMM) || (w_op == idcu_pkg::OP_JUMP)
           || (w_op == idcu_pkg::OP_MEM && w_sub < idcu_pkg::SUB_STORE_IND)
           || (w_op == idcu_pkg::OP_STACK && w_sub == idcu_pkg::SUB_POP);
        o_result.operand_controls.has_addr =
              (w_op == idcu_pkg::OP_MEM)
           || (w_op == idcu_pkg::OP_JUMP && w_taken)
           || (w_op == idcu_pkg::OP_STACK && w_sub == idcu_pkg::SUB_POP);
        o_result.operand_controls.mem_to_reg =
            (w_op == idcu_pkg::OP_MEM && (w_sub == idcu_pkg::SUB_LOAD_DIR
                                        || w_sub == idcu_pkg::SUB_LOAD_IND));
        o_result.operand_controls.reg_is_addr =
            (w_op == idcu_pkg::OP_MEM && (w_sub == idcu_pkg::SUB_STORE_IND
                                        || w_sub == idcu_pkg::SUB_LOAD_IND));

        // Program counter and stack controls.
        o_result.flow_controls.load_pc      = (w_op == idcu_pkg::OP_JUMP);
        o_result.flow_controls.stack_pop    =
              (w_op == idcu_pkg::OP_JUMP && w_sub == idcu_pkg::SUB_RTS)
           || (w_op == idcu_pkg::OP_STACK && w_sub == idcu_pkg::SUB_POP);
        o_result.flow_controls.stack_change =
              (w_op == idcu_pkg::OP_JUMP && (w_sub == idcu_pkg::SUB_JSR
                                           || w_sub == idcu_pkg::SUB_RTS))
           || (w_op == idcu_pkg::OP_STACK);
        o_result.flow_controls.jsr = (w_op == idcu_pkg::OP_JUMP && w_sub == idcu_pkg::SUB_JSR);
        o_result.flow_controls.ret = (w_op == idcu_pkg::OP_JUMP && w_sub == idcu_pkg::SUB_RTS);

        // Halt and I/O; output sub-opcodes past the last port still drive use-output.
        o_result.io_halt_controls.halt    = (w_op == idcu_pkg::OP_IO && w_sub == idcu_pkg::SUB_HALT);
        o_result.io_halt_controls.use_in  = (w_op == idcu_pkg::OP_IO && w_in_range);
        o_result.io_halt_controls.use_out = (w_op == idcu_pkg::OP_IO && w_out_any);

        if (w_op == idcu_pkg::OP_IO && w_in_range) begin
            o_result.io_port_number = idcu_pkg::PORT_W'(w_sub - idcu_pkg::SUB_IN_FIRST);
        end else if (w_op == idcu_pkg::OP_IO && w_out_range) begin
            o_result.io_port_number = idcu_pkg::PORT_W'(w_sub - idcu_pkg::SUB_OUT_FIRST);
        end else begin
            o_result.io_port_number = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/instruction_decode_control_unit.sv =====
// Instruction decode control unit: each input item carries a 16-bit instruction word and four
// condition flags, and yields one item of control signals (ALU operation, register numbers,
// write enables, operand and addressing controls, program-counter and stack controls, halt and
// I/O controls with the port number). An item passes through an input register, one level of
// decode logic and a result register, and its result is offered while it sits in the result
// register. One item is accepted in every cycle while the result side keeps taking items.
// The input register acts as the skid stage: an item can be accepted while a finished result
// still waits. The unit keeps no state between items.
`default_nettype none

module instruction_decode_control_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // Fields from bit 0: instruction_word[15:0], flag_bits[19:16], zero fill.
    input  wire logic [idcu_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // Fields from bit 0: alu_operation[4:0], dest_register[7:5], source_a_register[10:8],
    // source_b_register[13:11], io_port_number[15:14], write_enables[18:16],
    // operand_controls[22:19], flow_controls[27:23], io_halt_controls[30:28], zero fill.
    output logic [idcu_pkg::OUT_TDATA_W-1:0]         o_m_tdata
);

    `include "instruction_decode_control_unit_defines.svh"

    logic                             r_in_valid;
    logic                             n_in_valid;
    logic [idcu_pkg::WORD_W-1:0]      r_word;
    logic [idcu_pkg::FLAGS_W-1:0]     r_flags;
    logic                             r_out_valid;
    logic                             n_out_valid;
    idcu_pkg::t_result                r_out_res;
    idcu_pkg::t_result                w_res;
    logic                             w_adv_out;
    logic                             w_take_in;

    // Handshake: the result stage moves when empty or drained; the input stage follows it.
    assign w_adv_out  = ~r_out_valid | i_m_tready;
    assign o_s_tready = ~r_in_valid | w_adv_out;
    assign w_take_in  = i_s_tvalid & o_s_tready;

    assign n_in_valid  = w_take_in | (r_in_valid & ~w_adv_out);
    assign n_out_valid = w_adv_out ? r_in_valid : r_out_valid;

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_word  <= i_s_tdata[15:0];
            r_flags <= i_s_tdata[19:16];
        end
    end

    idcu_decode u_decode (
        .i_word   (r_word),
        .i_flags  (r_flags),
        .o_result (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_adv_out && r_in_valid) begin
            r_out_res <= w_res;
        end
    end

    // Pack the result item onto the output stream.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0,
                         r_out_res.io_halt_controls,
                         r_out_res.flow_controls,
                         r_out_res.operand_controls,
                         r_out_res.write_enables,
                         r_out_res.io_port_number,
                         r_out_res.source_b_register,
                         r_out_res.source_a_register,
                         r_out_res.dest_register,
                         r_out_res.alu_operation};

    // Both stages are empty after reset.
    `IDCU_ASSERT_RESET(a_reset_empty, !i_rst_n, !r_in_valid && !r_out_valid)
    // An accepted item is held in the input stage in the next cycle.
    `IDCU_ASSERT_NEXT(a_take_holds, i_s_tvalid && o_s_tready, r_in_valid)
    // An item in the input stage moves to an empty result stage at once.
    `IDCU_ASSERT_NEXT(a_moves_on, r_in_valid && !r_out_valid, r_out_valid)
    // A subroutine call always changes the stack.
    `IDCU_ASSERT_SAME(a_jsr_stack, r_out_valid && r_out_res.flow_controls.jsr,
                      r_out_res.flow_controls.stack_change)

endmodule

`default_nettype wire
